/* design/oqp_pkg.sv */
// Shared constants, codes and controller/datapath interface types.
package oqp_pkg;

  localparam int MAX_RANKS = 16;
  localparam int LOAD_BITS = 24;
  localparam int WT_W      = 8;
  localparam int RANK_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int CFG_W     = 5;
  localparam int TL_W      = LOAD_BITS + RANK_W;
  localparam int TC_W      = WT_W + RANK_W;
  localparam int AVG_W     = TL_W;
  localparam int VAL_W     = AVG_W + WT_W;
  localparam int DCNT_W    = $clog2(AVG_W);

  localparam logic CFG_OWN_RANK   = 1'b0;
  localparam logic CFG_RANK_COUNT = 1'b1;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_PLAN   = 2'd1,
    REQ_SELECT = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_DIVI,
    S_DIV,
    S_INIT,
    S_TOUT,
    S_STEP,
    S_MOVE,
    S_APPLY,
    S_CHK,
    S_LDIN,
    S_COPY,
    S_WRAP,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic load_wr;
    logic plan_start;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic init0;
    logic tout;
    logic adv_out;
    logic adv_in;
    logic move;
    logic apply;
    logic ldin;
    logic copy_step;
    logic sel_start;
    logic wrap_step;
    logic scan_step;
    logic fin;
    logic res_err;
    logic res_sel;
  } cmd_t;

  typedef struct packed {
    logic sum_last;
    logic cons_zero;
    logic div_last;
    logic step_go;
    logic same_rank;
    logic outr_last;
    logic in_done;
    logic copy_last;
    logic wrap_ge;
    logic scan_hit;
    logic scan_last;
  } status_t;

endpackage

/* design/offload_quota_planner_and_victim_picker.sv */
// Top level: offload quota planner and victim picker.
//
// A transaction is accepted at a rising edge where start_i is high and
// busy_o is low; req_type_i selects a rank load write, a plan or a select.
// Each transaction produces exactly one result, shown on victim_found_o,
// victim_rank_o and plan_error_o for one cycle while done_o is high.
// A load write or an unused request type answers in the cycle after
// acceptance. A plan sums the tables, tests for zero consumers, runs the
// serial divider for the average, does the two-pointer matching and
// reloads credits; zero consumers end it after the test. A select wraps
// the scan pointer into range and then scans up to n ranks, one rank a
// cycle, where n is the number of active ranks. The result follows the
// last busy cycle. Configuration is written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must write it only while the block is idle,
// which the block itself does not enforce. Reset clears quotas, credits
// and the scan pointer and sets own rank to 0 and rank count to 16; rank
// tables are undefined until written. The receiver cannot stall, so
// results are never held back.
module offload_quota_planner_and_victim_picker
  import oqp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [1:0]           req_type_i,
  input  logic [RANK_W-1:0]    rank_index_i,
  input  logic [LOAD_BITS-1:0] cell_load_i,
  input  logic [WT_W-1:0]      consumer_weight_i,
  output logic                 done_o,
  output logic                 victim_found_o,
  output logic [RANK_W-1:0]    victim_rank_o,
  output logic                 plan_error_o
);

  cmd_t    cmd;
  status_t status;
  logic    own_hit;

  oqp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  oqp_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .rank_index_i      (rank_index_i),
    .cell_load_i       (cell_load_i),
    .consumer_weight_i (consumer_weight_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .own_hit_o         (own_hit),
    .done_o            (done_o),
    .victim_found_o    (victim_found_o),
    .victim_rank_o     (victim_rank_o),
    .plan_error_o      (plan_error_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> (!victim_found_o && !plan_error_o))
    else $error("result flags set without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(victim_found_o && plan_error_o))
    else $error("select and plan flags set together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted transaction neither busy nor finished");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    victim_found_o |-> !own_hit)
    else $error("own rank picked as victim");

endmodule

/* design/oqp_ctrl.sv */
// Controller state machine sequencing load, plan and select transactions.
module oqp_ctrl
  import oqp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] req_type_i,
  input  status_t    status_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_e'(req_type_i))
            REQ_PLAN:   state_d = S_SUM;
            REQ_SELECT: state_d = S_WRAP;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SUM:   state_d = status_i.sum_last ? S_DIVI : S_SUM;
      S_DIVI:  state_d = status_i.cons_zero ? S_IDLE : S_DIV;
      S_DIV:   state_d = status_i.div_last ? S_INIT : S_DIV;
      S_INIT:  state_d = S_TOUT;
      S_TOUT:  state_d = S_STEP;
      S_STEP: begin
        if (!status_i.step_go) begin
          state_d = status_i.outr_last ? S_COPY : S_TOUT;
        end else if (status_i.same_rank) begin
          state_d = S_LDIN;
        end else begin
          state_d = S_MOVE;
        end
      end
      S_MOVE:  state_d = S_APPLY;
      S_APPLY: state_d = S_CHK;
      S_CHK:   state_d = status_i.in_done ? S_LDIN : S_STEP;
      S_LDIN:  state_d = S_STEP;
      S_COPY:  state_d = status_i.copy_last ? S_IDLE : S_COPY;
      S_WRAP:  state_d = status_i.wrap_ge ? S_WRAP : S_SCAN;
      S_SCAN:  state_d = (status_i.scan_hit || status_i.scan_last) ? S_IDLE : S_SCAN;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_e'(req_type_i))
            REQ_LOAD: begin
              cmd_o.load_wr = 1'b1;
              cmd_o.fin     = 1'b1;
            end
            REQ_PLAN:   cmd_o.plan_start = 1'b1;
            REQ_SELECT: cmd_o.sel_start  = 1'b1;
            default:    cmd_o.fin        = 1'b1;
          endcase
        end
      end
      S_SUM: cmd_o.sum_step = 1'b1;
      S_DIVI: begin
        if (status_i.cons_zero) begin
          cmd_o.fin     = 1'b1;
          cmd_o.res_err = 1'b1;
        end else begin
          cmd_o.div_init = 1'b1;
        end
      end
      S_DIV:  cmd_o.div_step = 1'b1;
      S_INIT: cmd_o.init0    = 1'b1;
      S_TOUT: cmd_o.tout     = 1'b1;
      S_STEP: begin
        if (!status_i.step_go) begin
          cmd_o.adv_out = 1'b1;
        end else if (status_i.same_rank) begin
          cmd_o.adv_in = 1'b1;
        end
      end
      S_MOVE:  cmd_o.move  = 1'b1;
      S_APPLY: cmd_o.apply = 1'b1;
      S_CHK:   cmd_o.adv_in = status_i.in_done;
      S_LDIN:  cmd_o.ldin  = 1'b1;
      S_COPY: begin
        cmd_o.copy_step = 1'b1;
        cmd_o.fin       = status_i.copy_last;
      end
      S_WRAP: cmd_o.wrap_step = status_i.wrap_ge;
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.fin       = status_i.scan_hit || status_i.scan_last;
        cmd_o.res_sel   = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* design/oqp_datapath.sv */
// Datapath: rank tables, sums, serial divider, matching registers and scan.
module oqp_datapath
  import oqp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [RANK_W-1:0]    rank_index_i,
  input  logic [LOAD_BITS-1:0] cell_load_i,
  input  logic [WT_W-1:0]      consumer_weight_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output logic                 own_hit_o,
  output logic                 done_o,
  output logic                 victim_found_o,
  output logic [RANK_W-1:0]    victim_rank_o,
  output logic                 plan_error_o
);

  logic [RANK_W-1:0]    own_q;
  logic [COUNT_W-1:0]   cnt_q;
  logic [LOAD_BITS-1:0] load_q   [MAX_RANKS];
  logic [WT_W-1:0]      wt_q     [MAX_RANKS];
  logic [LOAD_BITS-1:0] quota_q  [MAX_RANKS];
  logic [LOAD_BITS-1:0] credit_q [MAX_RANKS];
  logic [RANK_W-1:0]    sp_q, pos_q;
  logic [COUNT_W-1:0]   idx_q, outr_q, inr_q;
  logic [TL_W-1:0]      tl_q;
  logic [TC_W-1:0]      tc_q, rem_q;
  logic [AVG_W-1:0]     quo_q;
  logic [DCNT_W-1:0]    dcnt_q;
  logic [VAL_W-1:0]     out_l_q, in_l_q, tgt_in_q, tgt_out_q, mv_q;
  logic                 mvok_q;
  logic                 done_q, found_q, err_q;
  logic [RANK_W-1:0]    victim_q;

  logic [COUNT_W-1:0]   n_act, outr_nx;
  logic [RANK_W-1:0]    raddr, pos_nx;
  logic [LOAD_BITS-1:0] rd_load;
  logic [WT_W-1:0]      rd_wt;
  logic [VAL_W-1:0]     prod, need, spare;
  logic [TC_W:0]        dr;
  logic                 dge, hit;

  always_comb begin
    if (cnt_q == '0) begin
      n_act = COUNT_W'(1);
    end else if (cnt_q > COUNT_W'(MAX_RANKS)) begin
      n_act = COUNT_W'(MAX_RANKS);
    end else begin
      n_act = cnt_q;
    end
  end

  assign outr_nx = outr_q + COUNT_W'(1);

  always_comb begin
    raddr = idx_q[RANK_W-1:0];
    if (cmd_i.init0) begin
      raddr = '0;
    end else if (cmd_i.tout) begin
      raddr = outr_q[RANK_W-1:0];
    end else if (cmd_i.adv_out) begin
      raddr = outr_nx[RANK_W-1:0];
    end else if (cmd_i.ldin) begin
      raddr = inr_q[RANK_W-1:0];
    end
  end

  assign rd_load = load_q[raddr];
  assign rd_wt   = wt_q[raddr];
  assign prod    = VAL_W'(rd_wt) * VAL_W'(quo_q);
  assign need    = tgt_out_q - out_l_q;
  assign spare   = in_l_q - tgt_in_q;
  assign dr      = {rem_q, quo_q[AVG_W-1]};
  assign dge     = dr >= {1'b0, tc_q};
  assign hit     = (pos_q != own_q) && (credit_q[pos_q] != '0);
  assign pos_nx  = ({1'b0, pos_q} + COUNT_W'(1) == n_act) ? '0 : pos_q + RANK_W'(1);

  always_comb begin
    status_o.sum_last  = (idx_q == n_act - COUNT_W'(1));
    status_o.cons_zero = (tc_q == '0);
    status_o.div_last  = (dcnt_q == DCNT_W'(AVG_W - 1));
    status_o.step_go   = (out_l_q < tgt_out_q) && (inr_q < n_act);
    status_o.same_rank = (outr_q == inr_q);
    status_o.outr_last = (outr_nx >= n_act);
    status_o.in_done   = (in_l_q <= tgt_in_q);
    status_o.copy_last = (idx_q == n_act - COUNT_W'(1));
    status_o.wrap_ge   = ({1'b0, pos_q} >= n_act);
    status_o.scan_hit  = hit;
    status_o.scan_last = (idx_q == n_act - COUNT_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q <= '0;
      cnt_q <= COUNT_W'(MAX_RANKS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_RANK:   own_q <= cfg_data_i[RANK_W-1:0];
        CFG_RANK_COUNT: cnt_q <= cfg_data_i[COUNT_W-1:0];
        default:        own_q <= own_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      load_q[rank_index_i] <= cell_load_i;
      wt_q[rank_index_i]   <= consumer_weight_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_RANKS; i++) begin
        quota_q[i]  <= '0;
        credit_q[i] <= '0;
      end
      sp_q <= '0;
    end else begin
      if (cmd_i.apply && mvok_q && (inr_q == {1'b0, own_q})) begin
        quota_q[outr_q[RANK_W-1:0]] <= mv_q[LOAD_BITS-1:0];
      end
      if (cmd_i.copy_step) begin
        credit_q[idx_q[RANK_W-1:0]] <= quota_q[idx_q[RANK_W-1:0]];
      end
      if (cmd_i.scan_step) begin
        sp_q <= pos_nx;
        if (hit) begin
          credit_q[pos_q] <= credit_q[pos_q] - LOAD_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan_start || cmd_i.sel_start || cmd_i.adv_out) begin
      idx_q <= '0;
    end else if (cmd_i.sum_step || cmd_i.copy_step || cmd_i.scan_step) begin
      idx_q <= idx_q + COUNT_W'(1);
    end
    if (cmd_i.plan_start) begin
      tl_q <= '0;
      tc_q <= '0;
    end else if (cmd_i.sum_step) begin
      tl_q <= tl_q + TL_W'(rd_load);
      tc_q <= tc_q + TC_W'(rd_wt);
    end
    if (cmd_i.div_init) begin
      quo_q  <= tl_q;
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q  <= {quo_q[AVG_W-2:0], dge};
      rem_q  <= dge ? TC_W'(dr - {1'b0, tc_q}) : dr[TC_W-1:0];
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
    if (cmd_i.init0) begin
      in_l_q   <= VAL_W'(rd_load);
      out_l_q  <= VAL_W'(rd_load);
      tgt_in_q <= prod;
      outr_q   <= '0;
      inr_q    <= '0;
    end
    if (cmd_i.tout) begin
      tgt_out_q <= prod;
    end
    if (cmd_i.adv_out) begin
      outr_q  <= outr_nx;
      out_l_q <= VAL_W'(rd_load);
    end
    if (cmd_i.adv_in) begin
      inr_q <= inr_q + COUNT_W'(1);
    end
    if (cmd_i.move) begin
      mvok_q <= in_l_q > tgt_in_q;
      mv_q   <= (need < spare) ? need : spare;
    end
    if (cmd_i.apply && mvok_q) begin
      out_l_q <= out_l_q + mv_q;
      in_l_q  <= in_l_q - mv_q;
    end
    if (cmd_i.ldin && (inr_q < n_act)) begin
      in_l_q   <= VAL_W'(rd_load);
      tgt_in_q <= prod;
    end
    if (cmd_i.sel_start) begin
      pos_q <= sp_q;
    end else if (cmd_i.wrap_step) begin
      pos_q <= RANK_W'({1'b0, pos_q} - n_act);
    end else if (cmd_i.scan_step) begin
      pos_q <= pos_nx;
    end
    victim_q <= (cmd_i.res_sel && !hit) ? own_q : (cmd_i.res_sel ? pos_q : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q  <= 1'b0;
      found_q <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      done_q  <= cmd_i.fin;
      found_q <= cmd_i.fin && cmd_i.res_sel && hit;
      err_q   <= cmd_i.fin && cmd_i.res_err;
    end
  end

  assign own_hit_o      = (victim_q == own_q);
  assign done_o         = done_q;
  assign victim_found_o = found_q;
  assign victim_rank_o  = victim_q;
  assign plan_error_o   = err_q;

endmodule
